/* hw/rtl/steno_pkg.sv */
`default_nettype none

package steno_pkg;

    localparam int KEY_COUNT       = 34;
    localparam int HASH_KEY_COUNT  = 8;
    localparam int STAR_KEY_COUNT  = 4;
    localparam int RIGHT_KEY_COUNT = 10;
    localparam int LEFT_KEY_COUNT  = 6;

    // key positions in steno order
    localparam int KEY_S     = 8;
    localparam int KEY_LEFT  = 10;
    localparam int KEY_A     = 16;
    localparam int KEY_O     = 17;
    localparam int KEY_STAR  = 18;
    localparam int KEY_E     = 22;
    localparam int KEY_U     = 23;
    localparam int KEY_RIGHT = KEY_COUNT - RIGHT_KEY_COUNT;

    localparam logic [KEY_COUNT-1:0] DIGIT_MASK = 34'h0_5503_5700;

    // output slots, walked in order by the sequencer
    localparam int SLOT_HASH  = 0;
    localparam int SLOT_S     = 1;
    localparam int SLOT_LEFT  = 2;
    localparam int SLOT_A     = SLOT_LEFT + LEFT_KEY_COUNT;
    localparam int SLOT_O     = SLOT_A + 1;
    localparam int SLOT_STAR  = SLOT_O + 1;
    localparam int SLOT_E     = SLOT_STAR + 1;
    localparam int SLOT_U     = SLOT_E + 1;
    localparam int SLOT_DASH  = SLOT_U + 1;
    localparam int SLOT_RIGHT = SLOT_DASH + 1;
    localparam int NUM_SLOTS  = SLOT_RIGHT + RIGHT_KEY_COUNT;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);

    localparam int CHAR_W = 7;

    typedef logic [CHAR_W-1:0] char_t;

    localparam char_t LETTER_TBL [NUM_SLOTS] = '{
        7'h23, 7'h53, 7'h54, 7'h4b, 7'h50, 7'h57, 7'h48, 7'h52,
        7'h41, 7'h4f, 7'h2a, 7'h45, 7'h55, 7'h2d,
        7'h46, 7'h52, 7'h50, 7'h42, 7'h4c, 7'h47, 7'h54, 7'h53, 7'h44, 7'h5a
    };

    localparam char_t DIGIT_TBL [NUM_SLOTS] = '{
        7'h23, 7'h31, 7'h32, 7'h4b, 7'h33, 7'h57, 7'h34, 7'h52,
        7'h35, 7'h30, 7'h2a, 7'h45, 7'h55, 7'h2d,
        7'h36, 7'h52, 7'h37, 7'h42, 7'h38, 7'h47, 7'h39, 7'h53, 7'h44, 7'h5a
    };

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slot_en;
        logic                 num_mode;
    } slot_info_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

endpackage

`default_nettype wire

/* hw/rtl/steno_slot_map.sv */
`default_nettype none

module steno_slot_map (
    input  wire logic [steno_pkg::KEY_COUNT-1:0] chord,
    output steno_pkg::slot_info_t                slot_info
);

    logic hash_any;
    logic digit_any;
    logic vowel_any;
    logic right_any;

    always_comb
    begin
        hash_any  = |chord[0 +: steno_pkg::HASH_KEY_COUNT];
        digit_any = |(chord & steno_pkg::DIGIT_MASK);
        vowel_any = |chord[steno_pkg::KEY_A +: (steno_pkg::KEY_U - steno_pkg::KEY_A + 1)];
        right_any = |chord[steno_pkg::KEY_RIGHT +: steno_pkg::RIGHT_KEY_COUNT];

        slot_info.num_mode = hash_any & digit_any;

        slot_info.slot_en = '0;
        slot_info.slot_en[steno_pkg::SLOT_HASH] = hash_any & ~digit_any;
        slot_info.slot_en[steno_pkg::SLOT_S]    = |chord[steno_pkg::KEY_S +: 2];
        slot_info.slot_en[steno_pkg::SLOT_LEFT +: steno_pkg::LEFT_KEY_COUNT] =
            chord[steno_pkg::KEY_LEFT +: steno_pkg::LEFT_KEY_COUNT];
        slot_info.slot_en[steno_pkg::SLOT_A]    = chord[steno_pkg::KEY_A];
        slot_info.slot_en[steno_pkg::SLOT_O]    = chord[steno_pkg::KEY_O];
        // one asterisk however many of its keys are down
        slot_info.slot_en[steno_pkg::SLOT_STAR] =
            |chord[steno_pkg::KEY_STAR +: steno_pkg::STAR_KEY_COUNT];
        slot_info.slot_en[steno_pkg::SLOT_E]    = chord[steno_pkg::KEY_E];
        slot_info.slot_en[steno_pkg::SLOT_U]    = chord[steno_pkg::KEY_U];
        slot_info.slot_en[steno_pkg::SLOT_DASH] = right_any & ~vowel_any;
        slot_info.slot_en[steno_pkg::SLOT_RIGHT +: steno_pkg::RIGHT_KEY_COUNT] =
            chord[steno_pkg::KEY_RIGHT +: steno_pkg::RIGHT_KEY_COUNT];
    end

endmodule

`default_nettype wire

/* hw/rtl/steno_emit_seq.sv */
`default_nettype none

module steno_emit_seq (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [steno_pkg::KEY_COUNT-1:0] chord_in,
    input  wire steno_pkg::slot_info_t           slot_info,
    output logic [steno_pkg::KEY_COUNT-1:0]      work_chord,
    output logic                                 busy,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output steno_pkg::char_t                     char_code,
    output logic                                 last_char
);

    steno_pkg::seq_state_t state_reg, state_next;

    logic [steno_pkg::KEY_COUNT-1:0] work_chord_reg, work_chord_next;
    logic [steno_pkg::SLOT_W-1:0]    idx_reg, idx_next;
    logic                            out_valid_reg, out_valid_next;
    steno_pkg::char_t                char_reg, char_next;
    logic                            last_reg, last_next;

    logic                            running;
    logic                            out_ok;
    logic                            cur_en;
    logic [steno_pkg::NUM_SLOTS-1:0] rest;
    logic                            is_last;
    logic                            emit;
    logic                            step;

    always_comb
    begin
        out_ok  = ~out_valid_reg | ~out_stall;
        cur_en  = slot_info.slot_en[idx_reg];
        rest    = slot_info.slot_en >> idx_reg;
        is_last = ~|rest[steno_pkg::NUM_SLOTS-1:1];
        emit    = running & cur_en & out_ok;
        step    = running & (~cur_en | out_ok);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            steno_pkg::SEQ_IDLE:
            begin
                if (start)
                    state_next = steno_pkg::SEQ_RUN;
            end
            steno_pkg::SEQ_RUN:
            begin
                if (emit && is_last)
                    state_next = steno_pkg::SEQ_IDLE;
            end
            default:
            begin
                state_next = steno_pkg::SEQ_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        unique case (state_reg)
            steno_pkg::SEQ_IDLE:
            begin
                running = 1'b0;
                busy    = 1'b0;
            end
            steno_pkg::SEQ_RUN:
            begin
                running = 1'b1;
                busy    = 1'b1;
            end
            default:
            begin
                running = 1'b0;
                busy    = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        work_chord_next = work_chord_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        char_next       = char_reg;
        last_next       = last_reg;

        if (start)
        begin
            work_chord_next = chord_in;
            idx_next        = '0;
        end
        else if (step)
        begin
            idx_next = steno_pkg::SLOT_W'(idx_reg + 1'b1);
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            char_next      = slot_info.num_mode ? steno_pkg::DIGIT_TBL[idx_reg]
                                                : steno_pkg::LETTER_TBL[idx_reg];
            last_next      = is_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= steno_pkg::SEQ_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_chord_reg <= work_chord_next;
        char_reg       <= char_next;
        last_reg       <= last_next;
    end

    assign work_chord = work_chord_reg;
    assign out_valid  = out_valid_reg;
    assign char_code  = char_reg;
    assign last_char  = last_reg;

`ifndef SYNTH
    a_run_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == steno_pkg::SEQ_RUN |-> slot_info.slot_en != '0)
        else $error("sequencer running with no slot to emit");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == steno_pkg::SEQ_IDLE)
        else $error("stroke started while sequencer busy");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        emit && is_last |=> state_reg == steno_pkg::SEQ_IDLE && out_valid_reg && last_reg)
        else $error("final character did not end the stroke");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == steno_pkg::SEQ_RUN |-> idx_reg <= steno_pkg::SLOT_W'(steno_pkg::NUM_SLOTS - 1))
        else $error("slot index ran past the last slot");
`endif

endmodule

`default_nettype wire

/* hw/rtl/steno_chord_to_stroke_text_unit.sv */
// channel  direction  handshake             payload
// input    in         in_valid / in_stall   key_bits[33:0]
// output   out        out_valid / out_stall char_code[6:0], last_char
//
// a scan with keys down is taken while in_stall is low and ORed into the held chord
// an all-released scan with a non-empty chord starts the slot sequencer, which
// walks the 24 character slots one per cycle while out_stall does not hold it, up to the last slot in use
// in_stall is high after that scan while the sequencer runs, which out_stall can prolong
// out_stall holds the sequencer on a slot that has a character to emit
// reset clears the held chord, the sequencer and the output valid
`default_nettype none

module steno_chord_to_stroke_text_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [steno_pkg::KEY_COUNT-1:0] key_bits,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [steno_pkg::CHAR_W-1:0]         char_code,
    output logic                                 last_char
);

    logic [steno_pkg::KEY_COUNT-1:0] held_chord_reg, held_chord_next;
    logic [steno_pkg::KEY_COUNT-1:0] work_chord;
    steno_pkg::slot_info_t           slot_info;
    logic                            busy;
    logic                            in_accept;
    logic                            start;

    assign in_stall  = busy;
    assign in_accept = in_valid & ~busy;
    assign start     = in_accept & ~|key_bits & |held_chord_reg;

    always_comb
    begin
        held_chord_next = held_chord_reg;
        if (in_accept)
        begin
            if (|key_bits)
                held_chord_next = held_chord_reg | key_bits;
            else
                held_chord_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_chord_reg <= '0;
        else
            held_chord_reg <= held_chord_next;
    end

    steno_slot_map u_slot_map (
        .chord     (work_chord),
        .slot_info (slot_info)
    );

    steno_emit_seq u_emit_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .chord_in   (held_chord_reg),
        .slot_info  (slot_info),
        .work_chord (work_chord),
        .busy       (busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .last_char  (last_char)
    );

endmodule

`default_nettype wire

/* sim/steno_stroke_checker.sv */
module steno_stroke_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic [steno_pkg::KEY_COUNT-1:0]     key_bits,
    input  wire logic                                out_valid,
    input  wire logic                                out_stall,
    input  wire logic [steno_pkg::CHAR_W-1:0]        char_code,
    input  wire logic                                last_char,
    output int                                       fail_count,
    output int                                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEYS = steno_pkg::KEY_COUNT;

    typedef logic [steno_pkg::CHAR_W-1:0] glyph_t;

    typedef struct packed {
        glyph_t code;
        logic   last;
    } stroke_char_t;

    // one byte per key, key 0 in the leftmost character
    localparam logic [8*KEYS-1:0] LETTER_GLYPHS = "########SSTKPWHRAO****EUFRPBLGTSDZ";
    localparam logic [8*KEYS-1:0] DIGIT_GLYPHS  = "########112K3W4R50****EU6R7B8G9SDZ";

    localparam glyph_t HASH_CHAR = 7'h23;
    localparam glyph_t DASH_CHAR = 7'h2d;

    localparam logic [KEYS-1:0] NUMBER_BAR = 34'h0_0000_00ff;
    localparam logic [KEYS-1:0] DIGIT_KEYS =
        (34'd1 << 8)  | (34'd1 << 9)  | (34'd1 << 10) | (34'd1 << 12) |
        (34'd1 << 14) | (34'd1 << 16) | (34'd1 << 17) | (34'd1 << 24) |
        (34'd1 << 26) | (34'd1 << 28) | (34'd1 << 30);

    stroke_char_t    stroke_chars [$];
    logic [KEYS-1:0] held_chord;

    function automatic glyph_t key_glyph(input int k, input logic num_mode);
        logic [7:0] glyph_byte;
        if (num_mode)
            glyph_byte = DIGIT_GLYPHS[8*(KEYS-1-k) +: 8];
        else
            glyph_byte = LETTER_GLYPHS[8*(KEYS-1-k) +: 8];
        return glyph_byte[steno_pkg::CHAR_W-1:0];
    endfunction

    // queue up the characters of one finished chord
    function automatic void spell_stroke(input logic [KEYS-1:0] chord);
        glyph_t       text [0:23];
        int           len;
        logic         num_mode;
        logic         right_any;
        logic         star_seen;
        logic         emit;
        stroke_char_t entry;
        len       = 0;
        star_seen = 1'b0;
        num_mode  = (|(chord & NUMBER_BAR)) && (|(chord & DIGIT_KEYS));
        right_any = |chord[KEYS-1:24];
        if ((|(chord & NUMBER_BAR)) && !num_mode)
        begin
            text[len] = HASH_CHAR;
            len = len + 1;
        end
        for (int k = 8; k < KEYS; k++)
        begin
            if (k == 16 && right_any && !(|chord[23:16]))
            begin
                text[len] = DASH_CHAR;
                len = len + 1;
            end
            emit = chord[k];
            // both S keys give a single S
            if (k == 9 && chord[8])
                emit = 1'b0;
            // asterisk keys give a single star
            if (k >= 18 && k <= 21)
            begin
                emit = chord[k] && !star_seen;
                star_seen = star_seen | chord[k];
            end
            if (emit)
            begin
                text[len] = key_glyph(k, num_mode);
                len = len + 1;
            end
        end
        for (int i = 0; i < len; i++)
        begin
            entry.code = text[i];
            entry.last = (i == len - 1);
            stroke_chars.push_back(entry);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stroke_char_t want;
        int           errs;
        if (!rst_n)
        begin
            held_chord = '0;
            stroke_chars.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (in_valid && !in_stall)
            begin
                if (key_bits != '0)
                    held_chord = held_chord | key_bits;
                else if (held_chord != '0)
                begin
                    spell_stroke(held_chord);
                    held_chord = '0;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (stroke_chars.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, got char_code %h last_char %b",
                             $time, char_code, last_char);
                    errs = errs + 1;
                end
                else
                begin
                    want = stroke_chars.pop_front();
                    if (char_code !== want.code)
                    begin
                        $display("%0t: char_code mismatch, expected %h, got %h",
                                 $time, want.code, char_code);
                        errs = errs + 1;
                    end
                    if (last_char !== want.last)
                    begin
                        $display("%0t: last_char mismatch, expected %b, got %b",
                                 $time, want.last, last_char);
                        errs = errs + 1;
                    end
                end
            end
            fail_count  <= fail_count + errs;
            outstanding <= stroke_chars.size();
        end
    end

endmodule

/* sim/tb_steno_chord_to_stroke_text_unit.sv */
module tb_steno_chord_to_stroke_text_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEYS = steno_pkg::KEY_COUNT;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [KEYS-1:0]               key_bits;
    logic                          out_valid;
    logic                          out_stall;
    logic [steno_pkg::CHAR_W-1:0]  char_code;
    logic                          last_char;

    int fail_count;
    int outstanding;
    int send_idle_pct;
    int stall_pct;
    int scans_sent;
    bit pressure_phase;

    steno_chord_to_stroke_text_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .key_bits  (key_bits),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

    steno_stroke_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .key_bits    (key_bits),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_code   (char_code),
        .last_char   (last_char),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off during the pressure phase
    initial
    begin : receiver
        int hold_left;
        bit held_once;
        out_stall = 1'b0;
        hold_left = 0;
        held_once = 0;
        forever
        begin
            @(negedge clk);
            if (pressure_phase && !held_once)
            begin
                held_once = 1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_scan(input logic [KEYS-1:0] scan);
        logic [63:0] junk;
        while ($urandom_range(99) < send_idle_pct)
        begin
            junk = {$urandom, $urandom};
            in_valid <= 1'b0;
            key_bits <= junk[KEYS-1:0];
            @(negedge clk);
        end
        in_valid <= 1'b1;
        key_bits <= scan;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [KEYS-1:0] random_keys();
        logic [63:0]     r1;
        logic [63:0]     r2;
        logic [KEYS-1:0] keys;
        r1 = {$urandom, $urandom};
        r2 = {$urandom, $urandom};
        case ($urandom_range(5))
            0: keys = r1[KEYS-1:0];
            1: keys = r1[KEYS-1:0] & r2[KEYS-1:0] & r2[63:30];
            2: keys = 34'd1 << $urandom_range(KEYS - 1);
            // number bar with digit keys
            3: keys = r1[KEYS-1:0] & (steno_pkg::DIGIT_MASK | 34'h0_0000_00ff);
            // number bar without any digit key
            4: keys = (r1[KEYS-1:0] & ~steno_pkg::DIGIT_MASK) | (34'd1 << $urandom_range(7));
            default: keys = r1[KEYS-1:0] & r2[KEYS-1:0];
        endcase
        if (keys == '0)
            keys = 34'd1 << $urandom_range(KEYS - 1);
        return keys;
    endfunction

    // one chord: a few scans with keys down, usually closed by a release
    task automatic random_stroke();
        int presses;
        presses = $urandom_range(1, 3);
        if ($urandom_range(9) == 0)
        begin
            offer_scan('0);
            scans_sent = scans_sent + 1;
        end
        repeat (presses)
        begin
            offer_scan(random_keys());
            scans_sent = scans_sent + 1;
        end
        if ($urandom_range(7) != 0)
        begin
            offer_scan('0);
            scans_sent = scans_sent + 1;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        key_bits       = '0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        pressure_phase = 0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // release with nothing held
        offer_scan('0);
        // every key: number mode, longest stroke
        offer_scan(34'h3_ffff_ffff);
        offer_scan('0);
        // lone number key
        offer_scan(34'h0_0000_0001);
        offer_scan('0);
        // number key with letters only
        offer_scan(34'h0_0000_0080 | (~steno_pkg::DIGIT_MASK & 34'h3_ffff_ff00));
        offer_scan('0);
        // every letter key
        offer_scan(34'h3_ffff_ff00);
        offer_scan('0);
        // right key alone needs the dash
        offer_scan(34'd1 << 24);
        offer_scan('0);
        // all asterisk keys
        offer_scan(34'h0_003c_0000);
        offer_scan('0);
        // both S keys
        offer_scan(34'h0_0000_0300);
        offer_scan('0);
        // chord spread over two scans
        offer_scan(34'h0_0000_0400);
        offer_scan(34'h2_0000_0000);
        offer_scan('0);
        // vowels only
        offer_scan(34'h0_00c3_0000);
        offer_scan('0);
        // digits on the right side
        offer_scan(34'h1_0100_0001);
        offer_scan('0);
        offer_scan('0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    stall_pct      = 0;
                    pressure_phase = 1;
                end
                1:
                begin
                    send_idle_pct  = 64;
                    stall_pct      = 0;
                    pressure_phase = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 64;
                end
                default:
                begin
                    send_idle_pct = 29;
                    stall_pct     = 29;
                end
            endcase
            scans_sent = 0;
            while (scans_sent < 62)
                random_stroke();
        end
        // close any chord still held
        offer_scan('0);
        in_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/steno_pkg.sv
hw/rtl/steno_slot_map.sv
hw/rtl/steno_emit_seq.sv
hw/rtl/steno_chord_to_stroke_text_unit.sv
sim/steno_stroke_checker.sv
sim/tb_steno_chord_to_stroke_text_unit.sv
